[hdl/rk4su_pkg.sv]
// Shared constants, types and stage codes for the RK4 stage update block.
package rk4su_pkg;

	localparam int ARRAY_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(ARRAY_DEPTH);
	localparam int IDX_W       = 16;
	localparam int STAGE_W     = 2;
	localparam int VAL_W       = 32;
	localparam int STEP_W      = 16;
	localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

	// deriv * h, signed 32 x unsigned 16
	localparam int PROD_W = VAL_W + STEP_W + 1;

	// Stage 3 numerator: k1 + 2k2 + 2k3 + k4 + 3 + 2*bias, then halved.
	// bias = 3 * 2^32 keeps the halved value positive and is a multiple of 3.
	localparam int NSUM_W = 37;
	localparam logic [NSUM_W-2:0] NSUM_OFFSET = 36'd25769803779;

	// floor(x / 3) = (x * DIV3_MAGIC) >> DIV3_SHIFT for x < 2^37
	localparam int DIVX_W       = 35;
	localparam int DIV3_MAGIC_W = 36;
	localparam logic [DIV3_MAGIC_W-1:0] DIV3_MAGIC = 36'd45812984491;
	localparam int DIV3_SHIFT   = 37;
	localparam int QUO_W        = 34;
	localparam logic [QUO_W-1:0] QUO_BIAS = 34'd4294967296;

	localparam int SUM_W = 35;

	typedef enum logic [STAGE_W-1:0] {
		STG_K1 = 2'd0,
		STG_K2 = 2'd1,
		STG_K3 = 2'd2,
		STG_K4 = 2'd3
	} stage_t;

	typedef struct packed {
		logic ld_pp;
		logic ld_q;
	} div_ctl_t;

endpackage

[hdl/rk4su_in_if.sv]
// Input channel: stage, element and derivative/value pair with valid/ready.
interface rk4su_in_if import rk4su_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STAGE_W-1:0] stage;
	logic [IDX_W-1:0]   element_index;
	logic [VAL_W-1:0]   deriv_re;
	logic [VAL_W-1:0]   deriv_im;
	logic [VAL_W-1:0]   value_re;
	logic [VAL_W-1:0]   value_im;

	modport source (
		output valid, stage, element_index, deriv_re, deriv_im, value_re, value_im,
		input  ready
	);
	modport sink (
		input  valid, stage, element_index, deriv_re, deriv_im, value_re, value_im,
		output ready
	);
endinterface

[hdl/rk4su_out_if.sv]
// Output channel: updated complex value with valid/ready.
interface rk4su_out_if import rk4su_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] new_re;
	logic [VAL_W-1:0] new_im;

	modport source (
		output valid, new_re, new_im,
		input  ready
	);
	modport sink (
		input  valid, new_re, new_im,
		output ready
	);
endinterface

[hdl/rk4_stage_update.sv]
// RK4 stage update: per-element read-modify-write of start value and slopes.
// A result passes stage 1 (item and RAM read), stages 2 to 4 and the output register.
// Throughput: one item per cycle unless the output stalls; each store is one single-port
// RAM, read once and written at most once per item; an item only writes stores it does not use.
// Reset clears pipeline valids and sets step_size to 655; stores are not cleared.
module rk4_stage_update import rk4su_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [STEP_W-1:0] cfg_wdata,
	rk4su_in_if.sink          req,
	rk4su_out_if.source       rsp
);

	localparam int MEM_W = 2 * VAL_W;

	logic [STEP_W-1:0] step_q;

	logic fire;
	logic go1, go2, go3, go4, go_o;
	logic v1_q, v2_q, v3_q, v4_q, vo_q;

	stage_t            stg_in;
	logic [ADDR_W-1:0] addr;
	logic signed [VAL_W-1:0]  deriv [2];
	logic signed [PROD_W-1:0] rnd [2];
	logic signed [VAL_W-1:0]  k_in [2];
	logic we_k1, we_k2, we_k3;

	logic [MEM_W-1:0] rd_start, rd_k1, rd_k2, rd_k3;

	stage_t                  stg_s1;
	logic signed [VAL_W-1:0] k_s1 [2];
	logic signed [VAL_W-1:0] val_s1 [2];

	logic signed [VAL_W-1:0]  y0_c [2];
	logic signed [VAL_W-1:0]  dys_c [2];
	logic signed [VAL_W:0]    half_c [2];
	logic signed [NSUM_W-1:0] nsum_c [2];

	logic                    is3_s2, is3_s3, is3_s4;
	logic signed [VAL_W-1:0] y0_s2 [2], y0_s3 [2], y0_s4 [2];
	logic signed [VAL_W-1:0] dys_s2 [2], dys_s3 [2], dys_s4 [2];
	logic [DIVX_W-1:0]       x_s2 [2];
	logic [QUO_W-1:0]        q_s4 [2];
	div_ctl_t                div_ctl;

	logic signed [SUM_W-1:0] dy_c [2];
	logic signed [SUM_W-1:0] sum_c [2];
	logic [VAL_W-1:0]        sat_c [2];
	logic [VAL_W-1:0]        new_q [2];

	// step size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	// stall chain: a stage loads when empty or when its successor loads
	assign go_o      = !vo_q || rsp.ready;
	assign go4       = !v4_q || go_o;
	assign go3       = !v3_q || go4;
	assign go2       = !v2_q || go3;
	assign go1       = !v1_q || go2;
	assign req.ready = go1;
	assign fire      = req.valid && go1;

	assign stg_in   = stage_t'(req.stage);
	assign addr     = req.element_index[ADDR_W-1:0];
	assign deriv[0] = req.deriv_re;
	assign deriv[1] = req.deriv_im;

	// k = round(deriv * h), ties up
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			rnd[c]  = deriv[c] * $signed({1'b0, step_q})
				+ $signed(PROD_W'(1) << (STEP_W - 1));
			k_in[c] = rnd[c][STEP_W +: VAL_W];
		end
	end

	assign we_k1 = fire && (stg_in == STG_K1);
	assign we_k2 = fire && (stg_in == STG_K2);
	assign we_k3 = fire && (stg_in == STG_K3);

	rk4su_ram #(.ADDR_W(ADDR_W), .DATA_W(MEM_W)) u_start_mem (
		.clk   (clk),
		.we    (we_k1),
		.re    (fire),
		.addr  (addr),
		.wdata ({req.value_im, req.value_re}),
		.rdata (rd_start)
	);

	rk4su_ram #(.ADDR_W(ADDR_W), .DATA_W(MEM_W)) u_k1_mem (
		.clk   (clk),
		.we    (we_k1),
		.re    (fire),
		.addr  (addr),
		.wdata ({k_in[1], k_in[0]}),
		.rdata (rd_k1)
	);

	rk4su_ram #(.ADDR_W(ADDR_W), .DATA_W(MEM_W)) u_k2_mem (
		.clk   (clk),
		.we    (we_k2),
		.re    (fire),
		.addr  (addr),
		.wdata ({k_in[1], k_in[0]}),
		.rdata (rd_k2)
	);

	rk4su_ram #(.ADDR_W(ADDR_W), .DATA_W(MEM_W)) u_k3_mem (
		.clk   (clk),
		.we    (we_k3),
		.re    (fire),
		.addr  (addr),
		.wdata ({k_in[1], k_in[0]}),
		.rdata (rd_k3)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (go1) begin
				v1_q <= req.valid;
			end
			if (go2) begin
				v2_q <= v1_q;
			end
			if (go3) begin
				v3_q <= v2_q;
			end
			if (go4) begin
				v4_q <= v3_q;
			end
			if (go_o) begin
				vo_q <= v4_q;
			end
		end
	end

	// stage 1: item registers, RAM data arrives alongside
	always_ff @(posedge clk) begin
		if (go1) begin
			stg_s1    <= stg_in;
			k_s1[0]   <= k_in[0];
			k_s1[1]   <= k_in[1];
			val_s1[0] <= req.value_re;
			val_s1[1] <= req.value_im;
		end
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			y0_c[c]   = (stg_s1 == STG_K1) ? val_s1[c]
				: $signed(rd_start[c*VAL_W +: VAL_W]);
			half_c[c] = ($signed((VAL_W+1)'(k_s1[c])) + $signed((VAL_W+1)'(1))) >>> 1;
			dys_c[c]  = (stg_s1 == STG_K3) ? k_s1[c] : half_c[c][VAL_W-1:0];
			nsum_c[c] = NSUM_W'($signed(rd_k1[c*VAL_W +: VAL_W]))
				+ (NSUM_W'($signed(rd_k2[c*VAL_W +: VAL_W])) <<< 1)
				+ (NSUM_W'($signed(rd_k3[c*VAL_W +: VAL_W])) <<< 1)
				+ NSUM_W'(k_s1[c])
				+ $signed({1'b0, NSUM_OFFSET});
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (go2) begin
			is3_s2 <= (stg_s1 == STG_K4);
			for (int c = 0; c < 2; c++) begin
				y0_s2[c]  <= y0_c[c];
				dys_s2[c] <= dys_c[c];
				x_s2[c]   <= nsum_c[c][DIVX_W:1];
			end
		end
	end

	assign div_ctl.ld_pp = go3;
	assign div_ctl.ld_q  = go4;

	rk4su_div3 u_div_re (
		.clk (clk),
		.ctl (div_ctl),
		.x   (x_s2[0]),
		.q   (q_s4[0])
	);

	rk4su_div3 u_div_im (
		.clk (clk),
		.ctl (div_ctl),
		.x   (x_s2[1]),
		.q   (q_s4[1])
	);

	// stages 3 and 4 carry the bypass terms beside the divider
	always_ff @(posedge clk) begin
		if (go3) begin
			is3_s3 <= is3_s2;
			y0_s3  <= y0_s2;
			dys_s3 <= dys_s2;
		end
		if (go4) begin
			is3_s4 <= is3_s3;
			y0_s4  <= y0_s3;
			dys_s4 <= dys_s3;
		end
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			dy_c[c]  = is3_s4 ? ($signed({1'b0, q_s4[c]}) - $signed({1'b0, QUO_BIAS}))
				: SUM_W'(dys_s4[c]);
			sum_c[c] = SUM_W'(y0_s4[c]) + dy_c[c];
			// saturate when the bits above the result disagree with its sign
			if (sum_c[c][SUM_W-1:VAL_W-1] == '0 || sum_c[c][SUM_W-1:VAL_W-1] == '1) begin
				sat_c[c] = sum_c[c][VAL_W-1:0];
			end else if (sum_c[c][SUM_W-1]) begin
				sat_c[c] = {1'b1, {(VAL_W-1){1'b0}}};
			end else begin
				sat_c[c] = {1'b0, {(VAL_W-1){1'b1}}};
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (go_o) begin
			new_q[0] <= sat_c[0];
			new_q[1] <= sat_c[1];
		end
	end

	assign rsp.valid  = vo_q;
	assign rsp.new_re = new_q[0];
	assign rsp.new_im = new_q[1];

`ifndef SYNTH
	// stage-3 quotient of the biased value lies in [2^31, 3*2^31)
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_q && is3_s4) |-> (q_s4[0][QUO_W-1:VAL_W-1] == 3'b001
			|| q_s4[0][QUO_W-1:VAL_W-1] == 3'b010))
		else $error("stage 3 quotient out of range");

	// a result only appears after an item sat in the last stage
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(v4_q))
		else $error("output valid without a stage 4 item");

	// start and k3 RAM read data must hold while no transfer is taken
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(rd_start) && $stable(rd_k3))
		else $error("RAM read data changed without a transfer");
`endif

endmodule

[hdl/rk4su_ram.sv]
// Single-port synchronous RAM, read-first, registered read data.
module rk4su_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
		if (we) begin
			mem[addr] <= wdata;
		end
	end

endmodule

[hdl/rk4su_div3.sv]
// Two-stage floor divide by 3 through a reciprocal split into partial products.
module rk4su_div3 import rk4su_pkg::*; (
	input  logic              clk,
	input  div_ctl_t          ctl,
	input  logic [DIVX_W-1:0] x,
	output logic [QUO_W-1:0]  q
);

	localparam int HALF  = DIV3_MAGIC_W / 2;
	localparam int PP_W  = 2 * HALF;
	localparam int TOT_W = DIVX_W + DIV3_MAGIC_W;

	logic [HALF-1:0]  xh, xl, mh, ml;
	logic [PP_W-1:0]  pp_hh_s3, pp_hl_s3, pp_lh_s3, pp_ll_s3;
	logic [TOT_W-1:0] total;

	assign xh = HALF'(x[DIVX_W-1:HALF]);
	assign xl = x[HALF-1:0];
	assign mh = DIV3_MAGIC[DIV3_MAGIC_W-1:HALF];
	assign ml = DIV3_MAGIC[HALF-1:0];

	always_ff @(posedge clk) begin
		if (ctl.ld_pp) begin
			pp_hh_s3 <= xh * mh;
			pp_hl_s3 <= xh * ml;
			pp_lh_s3 <= xl * mh;
			pp_ll_s3 <= xl * ml;
		end
	end

	assign total = (TOT_W'(pp_hh_s3) << PP_W)
		+ (TOT_W'(pp_hl_s3) << HALF)
		+ (TOT_W'(pp_lh_s3) << HALF)
		+ TOT_W'(pp_ll_s3);

	always_ff @(posedge clk) begin
		if (ctl.ld_q) begin
			q <= total[DIV3_SHIFT +: QUO_W];
		end
	end

endmodule

[sim/rk4_stage_update_test.sv]
// Self-checking testbench for the RK4 stage update block: directed rows, then random stage sequences.
`timescale 1ns / 1ps

module rk4_stage_update_test;
	import rk4su_pkg::*;

	localparam int N_DIRECTED      = 22;
	localparam int N_PHASES        = 6;
	localparam int ITEMS_PER_PHASE = 325;
	localparam int POOL_N          = 24;
	localparam int HOLD_CYCLES     = 64;
	localparam int DRAIN_CYCLES    = 16;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int MAX_PRINTS      = 40;
	localparam longint WORD_MAX    = 64'sd2147483647;
	localparam longint WORD_MIN    = -64'sd2147483648;

	localparam logic [STEP_W-1:0] PHASE_STEPS [N_PHASES] =
		'{STEP_RESET, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0000};
	localparam int PHASE_SRC_GAP    [N_PHASES] = '{15, 25, 0, 15, 30, 0};
	localparam int PHASE_SINK_STALL [N_PHASES] = '{15, 0, 25, 10, 30, 0};

	typedef struct packed {
		logic [VAL_W-1:0] re;
		logic [VAL_W-1:0] im;
	} cval_t;

	typedef struct packed {
		logic [STEP_W-1:0] h;
		stage_t            stg;
		logic [IDX_W-1:0]  idx;
		logic [VAL_W-1:0]  d_re;
		logic [VAL_W-1:0]  d_im;
		logic [VAL_W-1:0]  v_re;
		logic [VAL_W-1:0]  v_im;
		logic              typed;
		logic [VAL_W-1:0]  e_re;
		logic [VAL_W-1:0]  e_im;
	} step_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [STEP_W-1:0] cfg_wdata;

	rk4su_in_if  req_ch ();
	rk4su_out_if rsp_ch ();

	rk4_stage_update DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// per-element stores as the block should hold them
	cval_t             start_store  [ARRAY_DEPTH];
	cval_t             slope1_store [ARRAY_DEPTH];
	cval_t             slope2_store [ARRAY_DEPTH];
	cval_t             slope3_store [ARRAY_DEPTH];
	bit [2:0]          stores_written [ARRAY_DEPTH];
	logic [STEP_W-1:0] step_h;

	cval_t predicted_updates [$];

	logic [IDX_W-1:0] pool_idx  [POOL_N];
	stage_t           pool_next [POOL_N];
	int               last_slot;

	int src_gap_pct;
	int sink_stall_pct;
	int hold_requests;
	int hold_served;
	int sink_hold_left;
	int sink_stall_left;

	int mismatch_count;
	int results_seen;
	int directed_count;
	int random_count;
	int step_writes;
	int cycle_count;
	int stage_hits [4];

	// h column, stage, element, deriv re/im, value re/im, typed flag, typed result re/im
	step_row_t directed_rows [N_DIRECTED] = '{
		'{STEP_RESET, STG_K1, 16'h0000, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000,
			1'b1, 32'h7FFFFFFF, 32'h80000000},
		'{STEP_RESET, STG_K2, 16'h0000, 32'h0, 32'h0, 32'hA5A55A5A, 32'h12345678,
			1'b1, 32'h7FFFFFFF, 32'h80000000},
		'{STEP_RESET, STG_K3, 16'h0000, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h00000000,
			1'b1, 32'h7FFFFFFF, 32'h80000000},
		'{STEP_RESET, STG_K4, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
			1'b1, 32'h7FFFFFFF, 32'h80000000},
		'{STEP_RESET, STG_K4, 16'h0000, 32'h0, 32'h0, 32'h12345678, 32'hFFFFFFFF,
			1'b1, 32'h7FFFFFFF, 32'h80000000},
		'{STEP_RESET, STG_K1, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			1'b1, 32'h7FFFFFFF, 32'h80000000},
		'{STEP_RESET, STG_K2, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h55555555, 32'hAAAAAAAA,
			1'b1, 32'h7FFFFFFF, 32'h80000000},
		'{STEP_RESET, STG_K3, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0},
		'{STEP_RESET, STG_K4, 16'hFFFF, 32'h00010000, 32'hFFFF0000, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0},
		'{16'h0000, STG_K1, 16'h1234, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'hFFFF0000,
			1'b1, 32'h00010000, 32'hFFFF0000},
		'{16'h0000, STG_K2, 16'h1234, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0,
			1'b1, 32'h00010000, 32'hFFFF0000},
		'{16'h0000, STG_K3, 16'h1234, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0,
			1'b1, 32'h00010000, 32'hFFFF0000},
		'{16'h0000, STG_K4, 16'h1234, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0,
			1'b1, 32'h00010000, 32'hFFFF0000},
		'{16'hFFFF, STG_K1, 16'h8000, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0},
		'{16'hFFFF, STG_K2, 16'h8000, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			1'b0, 32'h0, 32'h0},
		'{16'hFFFF, STG_K3, 16'h8000, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0},
		'{16'hFFFF, STG_K4, 16'h8000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0},
		// h = 1/2: ties in the scaling round up
		'{16'h8000, STG_K1, 16'h0001, 32'h00000001, 32'hFFFFFFFF, 32'h0, 32'h0,
			1'b1, 32'h00000001, 32'h00000000},
		'{16'h8000, STG_K1, 16'h0002, 32'h00000003, 32'hFFFFFFFD, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0},
		'{16'h8000, STG_K2, 16'h0001, 32'h00000005, 32'hFFFFFFFB, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0},
		'{16'h8000, STG_K3, 16'h0001, 32'hFFFFFFFF, 32'h00000001, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0},
		'{16'h8000, STG_K4, 16'h0001, 32'h00000003, 32'hFFFFFFFD, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still pending", cycle_count,
			predicted_updates.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------- predictor ----------------

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	function automatic logic [VAL_W-1:0] clamp_word(longint x);
		if (x > WORD_MAX)
			return VAL_W'(WORD_MAX);
		if (x < WORD_MIN)
			return VAL_W'(WORD_MIN);
		return VAL_W'(x);
	endfunction

	// k = deriv * h, Q0.16 step, round to nearest with ties up
	function automatic logic [VAL_W-1:0] scale_by_step(logic [VAL_W-1:0] deriv);
		longint prod;
		prod = longint'($signed(deriv)) * longint'(step_h);
		return VAL_W'((prod + (longint'(1) <<< (STEP_W - 1))) >>> STEP_W);
	endfunction

	function automatic logic [VAL_W-1:0] lane_result(stage_t s, logic [VAL_W-1:0] val,
			logic [VAL_W-1:0] y0, logic [VAL_W-1:0] k1, logic [VAL_W-1:0] k2,
			logic [VAL_W-1:0] k3, logic [VAL_W-1:0] k);
		longint base;
		longint delta;
		base = (s == STG_K1) ? longint'($signed(val)) : longint'($signed(y0));
		case (s)
			STG_K1, STG_K2: delta = (longint'($signed(k)) + 1) >>> 1;
			STG_K3:         delta = longint'($signed(k));
			default:        delta = floor_div(longint'($signed(k1)) + 2 * longint'($signed(k2))
				+ 2 * longint'($signed(k3)) + longint'($signed(k)) + 3, 6);
		endcase
		return clamp_word(base + delta);
	endfunction

	function automatic cval_t predict_update(stage_t s, logic [IDX_W-1:0] idx, cval_t d,
			cval_t v);
		logic [ADDR_W-1:0] a;
		cval_t k;
		cval_t res;
		a = ADDR_W'(32'(idx) % ARRAY_DEPTH);
		k.re = scale_by_step(d.re);
		k.im = scale_by_step(d.im);
		res.re = lane_result(s, v.re, start_store[a].re, slope1_store[a].re,
			slope2_store[a].re, slope3_store[a].re, k.re);
		res.im = lane_result(s, v.im, start_store[a].im, slope1_store[a].im,
			slope2_store[a].im, slope3_store[a].im, k.im);
		case (s)
			STG_K1: begin
				start_store[a]  = v;
				slope1_store[a] = k;
			end
			STG_K2: slope2_store[a] = k;
			STG_K3: slope3_store[a] = k;
			default: ;
		endcase
		if (s != STG_K4)
			stores_written[a][int'(s)] = 1'b1;
		return res;
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("mismatch on %s at result %0d: got %h, want %h", what, results_seen, got,
				want);
	endtask

	always @(posedge clk) begin : check_results
		cval_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (predicted_updates.size() == 0) begin
				report_mismatch("result with nothing pending", rsp_ch.new_re, 'x);
			end else begin
				want = predicted_updates.pop_front();
				if (rsp_ch.new_re !== want.re)
					report_mismatch("new_re", rsp_ch.new_re, want.re);
				if (rsp_ch.new_im !== want.im)
					report_mismatch("new_im", rsp_ch.new_im, want.im);
			end
			results_seen++;
		end
	end

	// ---------------- receiver ----------------

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served    = hold_requests;
				sink_hold_left = HOLD_CYCLES;
			end
			if (sink_hold_left > 0) begin
				sink_hold_left--;
				rsp_ch.ready = 1'b0;
			end else if (sink_stall_left > 0) begin
				sink_stall_left--;
				rsp_ch.ready = 1'b0;
			end else if ($urandom_range(0, 99) < sink_stall_pct) begin
				sink_stall_left = $urandom_range(0, 2);
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	// ---------------- sender ----------------

	function automatic logic [VAL_W-1:0] random_word();
		case ($urandom_range(0, 7))
			0, 1:    return VAL_W'($urandom);
			2:       return 32'h7FFFFFFF;
			3:       return 32'h80000000;
			4, 5:    return VAL_W'($urandom_range(0, 2097152)) - 32'd1048576;
			default: return VAL_W'($signed($urandom) >>> $urandom_range(4, 14));
		endcase
	endfunction

	task automatic idle_input(int n);
		repeat (n) begin
			@(negedge clk);
			req_ch.valid         = 1'b0;
			req_ch.stage         = STAGE_W'($urandom);
			req_ch.element_index = IDX_W'($urandom);
			req_ch.deriv_re      = VAL_W'($urandom);
			req_ch.deriv_im      = VAL_W'($urandom);
			req_ch.value_re      = VAL_W'($urandom);
			req_ch.value_im      = VAL_W'($urandom);
		end
	endtask

	task automatic offer_item(stage_t s, logic [IDX_W-1:0] idx, cval_t d, cval_t v,
			logic typed, cval_t typed_val);
		cval_t predicted;
		@(negedge clk);
		req_ch.valid         = 1'b1;
		req_ch.stage         = s;
		req_ch.element_index = idx;
		req_ch.deriv_re      = d.re;
		req_ch.deriv_im      = d.im;
		req_ch.value_re      = v.re;
		req_ch.value_im      = v.im;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = predict_update(s, idx, d, v);
		predicted_updates.push_back(typed ? typed_val : predicted);
		stage_hits[int'(s)]++;
	endtask

	// stop offering and wait until every pending result has been taken
	task automatic settle_block();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (predicted_updates.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_step(logic [STEP_W-1:0] h);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = h;
		@(negedge clk);
		cfg_we = 1'b0;
		step_h = h;
		step_writes++;
	endtask

	// mostly stage 0..3 in order per element; some jumps, restarts and fresh elements
	task automatic pick_item(output stage_t s, output logic [IDX_W-1:0] idx);
		int r;
		int slot;
		r    = $urandom_range(0, 99);
		slot = -1;
		if (r < 8) begin
			idx = IDX_W'($urandom);
			s   = stage_t'(STAGE_W'($urandom_range(0, 3)));
		end else begin
			slot = (r < 35) ? last_slot : $urandom_range(0, POOL_N - 1);
			idx  = pool_idx[slot];
			if ($urandom_range(0, 99) < 80)
				s = pool_next[slot];
			else
				s = stage_t'(STAGE_W'($urandom_range(0, 3)));
		end
		// never read a store entry that was not written
		if (s != STG_K1 && !stores_written[idx][0])
			s = STG_K1;
		else if (s == STG_K4 && !stores_written[idx][1])
			s = STG_K2;
		else if (s == STG_K4 && !stores_written[idx][2])
			s = STG_K3;
		if (slot >= 0) begin
			pool_next[slot] = stage_t'(STAGE_W'(int'(s) + 1));
			last_slot       = slot;
		end
	endtask

	task automatic run_directed();
		step_row_t row;
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = directed_rows[i];
			if (row.h != step_h) begin
				settle_block();
				write_step(row.h);
			end
			offer_item(row.stg, row.idx, cval_t'{row.d_re, row.d_im},
				cval_t'{row.v_re, row.v_im}, row.typed, cval_t'{row.e_re, row.e_im});
			directed_count++;
		end
	endtask

	task automatic run_random_phase(int ph);
		logic [STEP_W-1:0] h;
		stage_t            s;
		logic [IDX_W-1:0]  idx;
		h = (ph == 3 || ph == N_PHASES - 1) ? STEP_W'($urandom) : PHASE_STEPS[ph];
		settle_block();
		write_step(h);
		src_gap_pct    = PHASE_SRC_GAP[ph];
		sink_stall_pct = PHASE_SINK_STALL[ph];
		for (int i = 0; i < POOL_N; i++) begin
			// every second pair of slots are neighbors
			pool_idx[i]  = (i % 4 == 1) ? pool_idx[i - 1] + 1'b1 : IDX_W'($urandom);
			pool_next[i] = STG_K1;
		end
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			if (ph == 1 && n == 40)
				hold_requests++;
			if (ph == 3 && n == 160)
				settle_block();
			if ($urandom_range(0, 99) < src_gap_pct)
				idle_input($urandom_range(1, 3));
			pick_item(s, idx);
			offer_item(s, idx, cval_t'{random_word(), random_word()},
				cval_t'{random_word(), random_word()}, 1'b0, '0);
			random_count++;
		end
	endtask

	// ---------------- sequence ----------------

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		req_ch.valid         = 1'b0;
		req_ch.stage         = '0;
		req_ch.element_index = '0;
		req_ch.deriv_re      = '0;
		req_ch.deriv_im      = '0;
		req_ch.value_re      = '0;
		req_ch.value_im      = '0;
		step_h               = STEP_RESET;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		run_directed();
		for (int ph = 0; ph < N_PHASES; ph++)
			run_random_phase(ph);

		settle_block();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d directed and %0d random transfers; stages 0-3: %0d/%0d/%0d/%0d",
			directed_count, random_count, stage_hits[0], stage_hits[1], stage_hits[2],
			stage_hits[3]);
		$display("%0d results compared over %0d step size writes, %0d mismatches",
			results_seen, step_writes, mismatch_count);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
